// ----- rtl/spbf_pkg.sv -----
`timescale 1ns / 1ps
// Shared package of the spectrum peak bin finder.
// Field widths, root iteration count and the controller/datapath interface types.
package spbf_pkg;

  localparam int unsigned PartW     = 16;
  localparam int unsigned MagW      = PartW + 1;
  localparam int unsigned SqW       = 2 * MagW;
  localparam int unsigned RadW      = 32;
  localparam int unsigned RootW     = 16;
  localparam int unsigned RemW      = RootW + 3;
  localparam int unsigned LevelW    = 8;
  localparam int unsigned BinW      = 6;
  localparam int unsigned RootSteps = RootW;
  localparam int unsigned StepW     = $clog2(RootSteps);
  localparam int unsigned BinsDef   = 64;

  typedef struct packed {
    logic load;
    logic square;
    logic sum;
    logic step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic last_step;
  } sts_t;

endpackage

// ----- rtl/spbf_ctrl.sv -----
`timescale 1ns / 1ps
// Controller of the spectrum peak bin finder: sequences one bin at a time.
// Uses spbf_pkg for the command and status types.
module spbf_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  spbf_pkg::sts_t sts_i,
  output spbf_pkg::cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQ   = 3'd1;
  localparam logic [2:0] S_SUM  = 3'd2;
  localparam logic [2:0] S_ROOT = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       in_acc;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cmd_o.load = 1'b1;
          state_d    = S_SQ;
        end
      end
      S_SQ: begin
        cmd_o.square = 1'b1;
        state_d      = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = S_ROOT;
      end
      S_ROOT: begin
        cmd_o.step = 1'b1;
        if (sts_i.last_step) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_acc_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == S_SQ)
    else $error("accepted word did not start the squaring step");
  a_commit_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> out_valid_q)
    else $error("committed result not presented");
  a_root_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROOT && sts_i.last_step) |=> state_q == S_DONE)
    else $error("root iteration did not finish");
`endif

endmodule

// ----- rtl/spbf_dp.sv -----
`timescale 1ns / 1ps
// Datapath of the spectrum peak bin finder: magnitude squares, bit-pair
// restoring square root, peak tracking and the output register. Uses spbf_pkg.
module spbf_dp #(
  parameter int unsigned BINS_PER_FRAME = spbf_pkg::BinsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  spbf_pkg::cmd_t                      cmd_i,
  output spbf_pkg::sts_t                      sts_o,
  input  logic signed [spbf_pkg::PartW-1:0]   re_part_i,
  input  logic signed [spbf_pkg::PartW-1:0]   im_part_i,
  output logic        [spbf_pkg::BinW-1:0]    bin_number_o,
  output logic        [spbf_pkg::LevelW-1:0]  bin_level_o,
  output logic        [spbf_pkg::BinW-1:0]    peak_bin_o,
  output logic                                frame_end_o
);

  localparam int unsigned CntW = (BINS_PER_FRAME > 1) ? $clog2(BINS_PER_FRAME) : 1;
  localparam int unsigned ExtW = CntW + spbf_pkg::BinW;
  localparam logic [CntW-1:0] LastIdx = CntW'(BINS_PER_FRAME - 1);

  logic [spbf_pkg::MagW-1:0]  mag_re_q, mag_im_q, mag_re_d, mag_im_d;
  logic [spbf_pkg::SqW-1:0]   sq_re_q, sq_im_q;
  logic [spbf_pkg::RadW-1:0]  rad_q;
  logic [spbf_pkg::RootW-1:0] root_q;
  logic [spbf_pkg::RemW-1:0]  rem_q, rem_sh, trial;
  logic [spbf_pkg::StepW-1:0] step_q;
  logic [spbf_pkg::SqW-1:0]   sum_w;

  logic [CntW-1:0]            cnt_q, best_bin_q, best_bin_new;
  logic [spbf_pkg::RootW-1:0] best_root_q, best_root_new;
  logic                       last;
  logic [ExtW-1:0]            cnt_ext, best_ext;

  logic [spbf_pkg::BinW-1:0]   bin_number_q, peak_bin_q;
  logic [spbf_pkg::LevelW-1:0] bin_level_q;
  logic                        frame_end_q;

  assign mag_re_d = re_part_i[spbf_pkg::PartW-1] ?
                    spbf_pkg::MagW'(-$signed({re_part_i[spbf_pkg::PartW-1], re_part_i})) :
                    {1'b0, re_part_i};
  assign mag_im_d = im_part_i[spbf_pkg::PartW-1] ?
                    spbf_pkg::MagW'(-$signed({im_part_i[spbf_pkg::PartW-1], im_part_i})) :
                    {1'b0, im_part_i};

  assign sum_w  = sq_re_q + sq_im_q;
  assign rem_sh = {rem_q[spbf_pkg::RemW-3:0], rad_q[spbf_pkg::RadW-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};

  assign sts_o.last_step = (step_q == spbf_pkg::StepW'(spbf_pkg::RootSteps - 1));

  assign last = (cnt_q == LastIdx);

  always_comb begin
    best_root_new = best_root_q;
    best_bin_new  = best_bin_q;
    if (cnt_q != '0 && root_q > best_root_q) begin
      best_root_new = root_q;
      best_bin_new  = cnt_q;
    end
  end

  assign cnt_ext  = {{spbf_pkg::BinW{1'b0}}, cnt_q};
  assign best_ext = {{spbf_pkg::BinW{1'b0}}, best_bin_new};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mag_re_q <= mag_re_d;
      mag_im_q <= mag_im_d;
    end
    if (cmd_i.square) begin
      sq_re_q <= mag_re_q * mag_re_q;
      sq_im_q <= mag_im_q * mag_im_q;
    end
    if (cmd_i.sum) begin
      rad_q  <= sum_w[spbf_pkg::RadW-1:0];
      root_q <= '0;
      rem_q  <= '0;
    end else if (cmd_i.step) begin
      rad_q <= {rad_q[spbf_pkg::RadW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_q  <= rem_sh - trial;
        root_q <= {root_q[spbf_pkg::RootW-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[spbf_pkg::RootW-2:0], 1'b0};
      end
    end
    if (cmd_i.commit) begin
      bin_number_q <= cnt_ext[spbf_pkg::BinW-1:0];
      bin_level_q  <= root_q[spbf_pkg::RootW-1 -: spbf_pkg::LevelW];
      peak_bin_q   <= last ? best_ext[spbf_pkg::BinW-1:0] : '0;
      frame_end_q  <= last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      cnt_q       <= '0;
      best_root_q <= '0;
      best_bin_q  <= '0;
    end else begin
      if (cmd_i.sum) begin
        step_q <= '0;
      end else if (cmd_i.step) begin
        step_q <= step_q + 1'b1;
      end
      if (cmd_i.commit) begin
        if (last) begin
          cnt_q       <= '0;
          best_root_q <= '0;
          best_bin_q  <= '0;
        end else begin
          cnt_q       <= cnt_q + 1'b1;
          best_root_q <= best_root_new;
          best_bin_q  <= best_bin_new;
        end
      end
    end
  end

  assign bin_number_o = bin_number_q;
  assign bin_level_o  = bin_level_q;
  assign peak_bin_o   = peak_bin_q;
  assign frame_end_o  = frame_end_q;

endmodule

// ----- rtl/spectrum_peak_bin_finder_core.sv -----
`timescale 1ns / 1ps
// Spectrum peak bin finder, top level.
// Joins spbf_ctrl and spbf_dp; types and defaults from spbf_pkg.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one FFT bin per word:
//   re_part_i and im_part_i, Q1.15, bins of a frame in natural order.
//   Output channel (out_valid_o/out_ready_i) returns one word per bin:
//   bin_number_o, bin_level_o = floor(|bin|) >> 8, and on the last bin of
//   a frame frame_end_o = 1 with peak_bin_o, the first bin (DC excluded)
//   holding the largest floored magnitude floor(|bin|), 0 if none exceeds zero.
//   Operands load at the accepting edge; the core then squares, adds, runs
//   the bit-pair square root iteration and commits the result to the output
//   register. A new bin is taken only after the previous one has been
//   committed, since the single shared root iterator serves one bin at a time.
//   The output word sits in its own register, so the next bin is taken
//   while a result waits; a stalled receiver holds the next result in the
//   datapath and the input stays not ready until the register frees.
//   Reset clears the bin counter and the peak tracker; a frame starts at
//   bin zero.
module spectrum_peak_bin_finder_core #(
  parameter int unsigned BINS_PER_FRAME = spbf_pkg::BinsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [spbf_pkg::PartW-1:0]  re_part_i,
  input  logic signed [spbf_pkg::PartW-1:0]  im_part_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic        [spbf_pkg::BinW-1:0]   bin_number_o,
  output logic        [spbf_pkg::LevelW-1:0] bin_level_o,
  output logic        [spbf_pkg::BinW-1:0]   peak_bin_o,
  output logic                               frame_end_o
);

  spbf_pkg::cmd_t cmd;
  spbf_pkg::sts_t sts;

  spbf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  spbf_dp #(
    .BINS_PER_FRAME (BINS_PER_FRAME)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .re_part_i    (re_part_i),
    .im_part_i    (im_part_i),
    .bin_number_o (bin_number_o),
    .bin_level_o  (bin_level_o),
    .peak_bin_o   (peak_bin_o),
    .frame_end_o  (frame_end_o)
  );

endmodule

// ----- tb/tb_spectrum_peak_bin_finder_core.sv -----
`timescale 1ns / 1ps
// Testbench for spectrum_peak_bin_finder_core: FFT bin words in, level/peak words out.
// Self-checking against an in-bench magnitude/peak predictor; needs spbf_pkg and the core.
module tb_spectrum_peak_bin_finder_core;
  import spbf_pkg::*;

  localparam int FrameLen = BinsDef;
  localparam int NumProbe = 22;
  localparam int NumRand  = 600;
  localparam int HoldLen  = 160;

  typedef struct packed {
    logic [BinW-1:0]   bin;
    logic [LevelW-1:0] level;
    logic [BinW-1:0]   peak;
    logic              last;
  } bin_word_t;

  typedef struct packed {
    logic signed [PartW-1:0] re;
    logic signed [PartW-1:0] im;
    logic                    fixed;
    bin_word_t               want;
  } probe_row_t;

  typedef enum logic [2:0] {
    FrmFull, FrmQuiet, FrmTies, FrmLow, FrmCorner, FrmSpike
  } frame_mode_e;

  // rows 0..12 carry hand-read results; the rest go through the predictor
  localparam probe_row_t Probes [NumProbe] = '{
    '{16'sh8000, 16'sh8000, 1'b1, '{6'd0, 8'd181, 6'd0, 1'b0}},
    '{16'sd0, 16'sd0, 1'b1, '{6'd1, 8'd0, 6'd0, 1'b0}},
    '{16'sd32767, 16'sd0, 1'b1, '{6'd2, 8'd127, 6'd0, 1'b0}},
    '{16'sh8000, 16'sd0, 1'b1, '{6'd3, 8'd128, 6'd0, 1'b0}},
    '{16'sd0, 16'sh8000, 1'b1, '{6'd4, 8'd128, 6'd0, 1'b0}},
    '{16'sd0, 16'sd32767, 1'b1, '{6'd5, 8'd127, 6'd0, 1'b0}},
    '{-16'sd1, -16'sd1, 1'b1, '{6'd6, 8'd0, 6'd0, 1'b0}},
    '{16'sd1, 16'sd0, 1'b1, '{6'd7, 8'd0, 6'd0, 1'b0}},
    '{16'sh8000, 16'sd32767, 1'b1, '{6'd8, 8'd181, 6'd0, 1'b0}},
    '{16'sd32767, 16'sh8000, 1'b1, '{6'd9, 8'd181, 6'd0, 1'b0}},
    '{16'sh8000, 16'sh8000, 1'b1, '{6'd10, 8'd181, 6'd0, 1'b0}},
    '{16'sd255, 16'sd0, 1'b1, '{6'd11, 8'd0, 6'd0, 1'b0}},
    '{16'sd256, 16'sd0, 1'b1, '{6'd12, 8'd1, 6'd0, 1'b0}},
    '{-16'sd181, -16'sd181, 1'b0, '0},
    '{16'sd23170, 16'sd23170, 1'b0, '0},
    '{16'sd12345, -16'sd23456, 1'b0, '0},
    '{-16'sd32767, 16'sd1, 1'b0, '0},
    '{16'sd1, -16'sd32767, 1'b0, '0},
    '{16'sd21845, -16'sd21846, 1'b0, '0},
    '{-16'sd21846, 16'sd21845, 1'b0, '0},
    '{16'sd100, -16'sd100, 1'b0, '0},
    '{-16'sd256, -16'sd255, 1'b0, '0}
  };

  localparam logic [PartW-1:0] Corners [6] = '{
    16'h8000, 16'h8001, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFF
  };

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_ready_o;
  logic signed [PartW-1:0] re_part_i   = '0;
  logic signed [PartW-1:0] im_part_i   = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic [BinW-1:0]         bin_number_o;
  logic [LevelW-1:0]       bin_level_o;
  logic [BinW-1:0]         peak_bin_o;
  logic                    frame_end_o;

  logic      row_fixed = 1'b0;
  bin_word_t row_want  = '0;

  bin_word_t pending_words [$];
  int        frame_idx = 0;
  int        top_root  = 0;
  int        top_bin   = 0;

  int tx_idle_pct = 6;
  int rx_idle_pct = 71;
  int rx_cycle    = 0;
  int hold_left   = 0;
  int n_sent      = 0;
  int n_checked   = 0;
  int n_frames    = 0;
  int n_bad       = 0;

  spectrum_peak_bin_finder_core #(
    .BINS_PER_FRAME(FrameLen)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .re_part_i   (re_part_i),
    .im_part_i   (im_part_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .bin_number_o(bin_number_o),
    .bin_level_o (bin_level_o),
    .peak_bin_o  (peak_bin_o),
    .frame_end_o (frame_end_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic int mag_root(input longint n);
    longint r;
    longint t;
    r = 0;
    for (int b = 15; b >= 0; b--) begin
      t = r | (longint'(1) << b);
      if (t * t <= n) r = t;
    end
    return int'(r);
  endfunction

  function automatic bin_word_t next_bin_word(input logic signed [PartW-1:0] re,
                                              input logic signed [PartW-1:0] im);
    int        a;
    int        b;
    int        root;
    logic      last;
    bin_word_t w;
    a = re;
    b = im;
    if (a < 0) a = -a;
    if (b < 0) b = -b;
    root = mag_root(longint'(a) * a + longint'(b) * b);
    last = (frame_idx + 1 >= FrameLen);
    // DC bin stays out of the peak search; ties keep the earlier bin
    if (frame_idx != 0 && root > top_root) begin
      top_root = root;
      top_bin  = frame_idx;
    end
    w.bin   = BinW'(frame_idx);
    w.level = LevelW'(root >> 8);
    w.peak  = last ? BinW'(top_bin) : '0;
    w.last  = last;
    if (last) begin
      frame_idx = 0;
      top_root  = 0;
      top_bin   = 0;
    end else begin
      frame_idx++;
    end
    return w;
  endfunction

  always @(posedge clk_i) begin
    bin_word_t w;
    if (rst_ni && in_valid_i && in_ready_o) begin
      w = next_bin_word(re_part_i, im_part_i);
      if (row_fixed) w = row_want;
      pending_words.push_back(w);
      n_sent++;
    end
  end

  always @(posedge clk_i) begin
    bin_word_t want;
    bin_word_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{bin_number_o, bin_level_o, peak_bin_o, frame_end_o};
      if (pending_words.size() == 0) begin
        if (n_bad < 10)
          $display("%0t: unexpected word bin %0d level %0d peak %0d end %0b",
                   $time, got.bin, got.level, got.peak, got.last);
        n_bad++;
      end else begin
        want = pending_words.pop_front();
        n_checked++;
        if (got.last) n_frames++;
        if (got !== want) begin
          if (n_bad < 10)
            $display({"%0t: mismatch want bin %0d level %0d peak %0d end %0b,",
                      " got bin %0d level %0d peak %0d end %0b"},
                     $time, want.bin, want.level, want.peak, want.last,
                     got.bin, got.level, got.peak, got.last);
          n_bad++;
        end
      end
    end
  end

  // receiver: random stalls plus two long hold-offs that back up the core
  always @(posedge clk_i) begin
    rx_cycle <= rx_cycle + 1;
    if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (rx_cycle == 1500 || rx_cycle == 7000) begin
      hold_left   <= HoldLen;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic push_word(input int re, input int im, input logic fixed,
                           input bin_word_t want);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    re_part_i  <= PartW'(re);
    im_part_i  <= PartW'(im);
    row_fixed  <= fixed;
    row_want   <= want;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_words.size() != 0);
  endtask

  initial begin
    frame_mode_e mode;
    int          pos;
    int          spike_at;
    int          tie_re;
    int          tie_im;
    int          lim;
    int          tmp;
    int          re;
    int          im;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int k = 0; k < NumProbe; k++)
      push_word(Probes[k].re, Probes[k].im, Probes[k].fixed, Probes[k].want);
    wait_drained();

    pos      = NumProbe;
    mode     = FrmFull;
    spike_at = 1;
    tie_re   = 1024;
    tie_im   = 0;
    for (int n = 0; n < NumRand; n++) begin
      if (n == 200) begin
        wait_drained();
        tx_idle_pct = 71;
        rx_idle_pct = 6;
      end else if (n == 400) begin
        wait_drained();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (pos == 0) begin
        mode   = frame_mode_e'($urandom_range(FrmSpike));
        tie_re = $urandom_range(32767, 1024);
        tie_im = $urandom_range(32767);
        case ($urandom_range(2))
          0:       spike_at = 1;
          1:       spike_at = FrameLen - 1;
          default: spike_at = $urandom_range(FrameLen - 1, 1);
        endcase
      end
      re = 0;
      im = 0;
      case (mode)
        FrmFull: begin
          re = $urandom;
          im = $urandom;
        end
        FrmQuiet: begin
          if (pos == 0) begin
            re = $urandom;
            im = $urandom;
          end
        end
        FrmTies: begin
          if ($urandom_range(3) == 0) begin
            re = tie_re;
            im = tie_im;
            if ($urandom_range(1) == 1) begin
              tmp = re;
              re  = im;
              im  = tmp;
            end
            if ($urandom_range(1) == 1) re = -re;
            if ($urandom_range(1) == 1) im = -im;
          end else begin
            lim = tie_re / 4;
            re  = $urandom_range(2 * lim) - lim;
            im  = $urandom_range(2 * lim) - lim;
          end
        end
        FrmLow: begin
          re = $urandom_range(600) - 300;
          im = $urandom_range(600) - 300;
        end
        FrmCorner: begin
          re = $signed(Corners[$urandom_range(5)]);
          im = $signed(Corners[$urandom_range(5)]);
        end
        default: begin
          if (pos == spike_at) begin
            re = $urandom_range(32767, 20000);
            if ($urandom_range(1) == 1) re = -re;
            im = $urandom;
          end else begin
            re = $urandom_range(2000) - 1000;
            im = $urandom_range(2000) - 1000;
          end
        end
      endcase
      push_word(re, im, 1'b0, '0);
      pos = (pos + 1) % FrameLen;
    end

    wait_drained();
    repeat (40) @(posedge clk_i);
    $display("Sent %0d bins, checked %0d words across %0d frames; content mixed full-range,",
             n_sent, n_checked, n_frames);
    $display("quiet, tied, low-level, corner and single-spike frames, with output stalls.");
    if (n_bad == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatching words", n_bad);
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d words outstanding", pending_words.size());
    $display("FAIL");
    $finish;
  end

endmodule
